>>> hdl/bse_pkg.sv
`timescale 1ns / 1ps

package bse_pkg;

    // Field widths of the channel words
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;

    // Presence memory: one byte holds eight values
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = 3;

    // APB port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    // register index, taken from paddr[PADDR_W-1] (byte address 4*i)
    localparam logic REG_LOWEST = 1'b0;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_NEXT   = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FOUND    = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_SCAN,
        S_RESULT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic clear;    // zero one memory word per cycle
        logic accept;   // input slot open
        logic decode;   // range check, start address, first read
        logic insert;   // write back the word with the new bit set
        logic scan;     // examine one word of the scan
        logic result;   // move the result into the output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_insert;
        logic in_range;
        logic has_start;
        logic hit;
        logic last_word;
        logic out_free;
        logic clr_last;
    } t_dp_stat;

endpackage

>>> hdl/bse_if.sv
`timescale 1ns / 1ps

// Command word channel
interface bse_in_if import bse_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// Result word channel
interface bse_out_if import bse_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  sorted_value;

    modport source (output valid, output status, output sorted_value, input ready);
    modport sink   (input valid, input status, input sorted_value, output ready);
endinterface

>>> hdl/bse_ctrl.sv
`timescale 1ns / 1ps

module bse_ctrl import bse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.is_insert) begin
                    n_state = i_stat.in_range ? S_INSERT : S_RESULT;
                end else begin
                    n_state = i_stat.has_start ? S_SCAN : S_RESULT;
                end
            end
            S_INSERT: begin
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.last_word) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR:  o_cmd.clear  = 1'b1;
            S_IDLE:   o_cmd.accept = 1'b1;
            S_DECODE: o_cmd.decode = 1'b1;
            S_INSERT: o_cmd.insert = 1'b1;
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_RESULT: o_cmd.result = 1'b1;
            default:  o_cmd        = '0;
        endcase
    end

    assign o_in_ready = o_cmd.accept;

endmodule

>>> hdl/bse_dpath.sv
`timescale 1ns / 1ps

module bse_dpath import bse_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [VALUE_W-1:0]  i_lowest,
    // input word
    input  logic                i_in_valid,
    input  logic                i_in_command,
    input  logic [VALUE_W-1:0]  i_in_value,
    // result word
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_out_status,
    output logic [VALUE_W-1:0]  o_out_value
);

    localparam int WORD_COUNT = (VALUE_BITS > BIT_W) ? (1 << (VALUE_BITS - BIT_W)) : 1;
    localparam int AW         = (VALUE_BITS > BIT_W) ? (VALUE_BITS - BIT_W) : 1;
    localparam int CW         = VALUE_BITS + 1;
    localparam int EW         = (CW > VALUE_W) ? CW : VALUE_W + 1;

    localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);
    localparam logic [CW-1:0] CUR_END   = CW'(1) << VALUE_BITS;
    localparam logic [EW-1:0] DOMAIN    = EW'(1) << VALUE_BITS;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    logic                 r_cmd;
    logic [VALUE_W-1:0]   r_value;
    logic [CW-1:0]        r_cursor;
    logic [AW-1:0]        r_word;
    logic [WORD_BITS-1:0] r_mask;
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_clr_addr;
    t_status              r_res_status;
    logic [VALUE_W-1:0]   r_res_value;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [VALUE_W-1:0]   r_out_value;

    logic [EW-1:0]        ext_value;
    logic [EW-1:0]        ext_low;
    logic [EW-1:0]        ext_cursor;
    logic [EW-1:0]        start;
    logic                 is_insert;
    logic                 in_range;
    logic                 has_start;
    logic [WORD_BITS-1:0] hit_vec;
    logic                 hit;
    logic                 last_word;
    logic [CW-1:0]        found;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 out_free;

    // Decode of the held command
    assign ext_value  = EW'(r_value);
    assign ext_low    = EW'(i_lowest);
    assign ext_cursor = EW'(r_cursor);
    assign start      = (ext_cursor < ext_low) ? ext_low : ext_cursor;
    assign is_insert  = (r_cmd == CMD_INSERT);
    assign in_range   = (ext_value >= ext_low) && (ext_value < DOMAIN);
    assign has_start  = (start < DOMAIN);

    // Word under examination during a scan
    assign hit_vec   = r_rdata & r_mask;
    assign hit       = |hit_vec;
    assign last_word = (r_word == LAST_WORD);
    assign found     = (CW'(r_word) << BIT_W) | CW'(first_set(hit_vec));

    assign out_free  = !r_out_valid || i_out_ready;

    // Memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_word + AW'(1);
        if (i_cmd.decode) begin
            rd_en   = is_insert ? in_range : has_start;
            rd_addr = is_insert ? AW'(ext_value >> BIT_W) : AW'(start >> BIT_W);
        end else if (i_cmd.scan) begin
            rd_en   = !hit && !last_word;
        end
        wr_en   = i_cmd.clear || i_cmd.insert;
        wr_addr = i_cmd.clear ? r_clr_addr : r_word;
        wr_data = i_cmd.clear ? '0 : (r_rdata | r_mask);
    end

    // Presence memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in_valid) begin
            r_cmd   <= i_in_command;
            r_value <= i_in_value;
        end
    end

    // Word address and bit mask of the access in flight
    always_ff @(posedge i_clk) begin
        if (rd_en) r_word <= rd_addr;
        if (i_cmd.decode) begin
            r_mask <= is_insert ? (WORD_BITS'(1) << ext_value[BIT_W-1:0])
                                : ({WORD_BITS{1'b1}} << start[BIT_W-1:0]);
        end else if (i_cmd.scan) begin
            r_mask <= '1;
        end
    end

    // Scan cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.decode && !is_insert && !has_start) begin
            r_cursor <= CUR_END;
        end else if (i_cmd.scan && hit) begin
            r_cursor <= found + CW'(1);
        end else if (i_cmd.scan && last_word) begin
            r_cursor <= CUR_END;
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_res_status <= is_insert ? ST_RANGE : ST_EMPTY;
            r_res_value  <= '0;
        end else if (i_cmd.insert) begin
            r_res_status <= ST_INSERTED;
            r_res_value  <= '0;
        end else if (i_cmd.scan && hit) begin
            r_res_status <= ST_FOUND;
            r_res_value  <= VALUE_W'(found);
        end else if (i_cmd.scan && last_word) begin
            r_res_status <= ST_EMPTY;
            r_res_value  <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result && out_free) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_value  = r_out_value;

    assign o_stat.is_insert = is_insert;
    assign o_stat.in_range  = in_range;
    assign o_stat.has_start = has_start;
    assign o_stat.hit       = hit;
    assign o_stat.last_word = last_word;
    assign o_stat.out_free  = out_free;
    assign o_stat.clr_last  = (r_clr_addr == LAST_WORD);

endmodule

>>> hdl/bitmap_sort_engine.sv
`timescale 1ns / 1ps
// Channel   Dir   Word                        Handshake
// i_in      in    command, value              valid / ready
// o_out     out   status, sorted_value        valid / ready
// APB       in    lowest_value at byte 0      psel, penable, pwrite, pready
//
// Insert: accept, decode with byte read, write-back, result; out of range: no write-back.
// Next: accept, decode, scan of each byte from the start byte to the hit or top, result.
// The scan reads one presence byte per cycle through the memory's single read port.
// After reset a clearing pass zeroes 2^(VALUE_BITS-3) bytes, one per cycle, with
// i_in.ready low. A stalled result is held in the output register; the next word
// is taken meanwhile and its result waits until the register frees.

module bitmap_sort_engine import bse_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bse_in_if.sink             i_in,
    bse_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [VALUE_W-1:0] r_lowest;
    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    logic               sel_lowest;

    // Configuration register
    assign sel_lowest = (paddr[PADDR_W-1] == REG_LOWEST);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest <= '0;
        end else if (psel && penable && pwrite && pready && sel_lowest) begin
            r_lowest <= pwdata[VALUE_W-1:0];
        end
    end

    assign prdata = sel_lowest ? PDATA_W'(r_lowest) : '0;

    bse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_ready (i_in.ready)
    );

    bse_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_lowest     (r_lowest),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_in_value   (i_in.value),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_status (o_out.status),
        .o_out_value  (o_out.sorted_value)
    );

endmodule

>>> hdl/bse_checker.sv
`timescale 1ns / 1ps

module bse_checker import bse_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic [VALUE_W-1:0]  i_out_value
);

    logic r_seen_empty;

    // Once a scan ran off the top, the cursor stays saturated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_empty <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_status == ST_EMPTY) begin
            r_seen_empty <= 1'b1;
        end
    end

    // Reset starts the clearing pass: no result, no word taken
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("result or input ready right after reset");

    // Only a found value carries a nonzero sorted_value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_FOUND |-> i_out_value == '0)
        else $error("sorted_value nonzero without a found status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_value))
        else $error("stalled result changed");

    // No value is found after the scan reported the end
    a_no_found_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_empty && i_out_valid |-> i_out_status != ST_FOUND)
        else $error("value found after the scan was exhausted");

endmodule

bind bitmap_sort_engine bse_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_value  (o_out.sorted_value)
);
